// ===== rtl/rid_pkg.sv =====
// rid_pkg: shared constants and types for the riff/iff audio deframer
// holds result kinds, error codes, parser phases, magic words and the result struct
// no dependencies
`timescale 1ns / 1ps

package rid_pkg;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [2:0] ERR_MAGIC    = 3'd0;
  localparam logic [2:0] ERR_NOT_PCM  = 3'd1;
  localparam logic [2:0] ERR_DEPTH    = 3'd2;
  localparam logic [2:0] ERR_HEADER   = 3'd3;
  localparam logic [2:0] ERR_CHANNEL  = 3'd4;

  localparam logic [3:0] PH_FILEHDR  = 4'd0;
  localparam logic [3:0] PH_CHUNKHDR = 4'd1;
  localparam logic [3:0] PH_FMT      = 4'd2;
  localparam logic [3:0] PH_VHDR     = 4'd3;
  localparam logic [3:0] PH_SKIP     = 4'd4;
  localparam logic [3:0] PH_DATA     = 4'd5;
  localparam logic [3:0] PH_PAD      = 4'd6;
  localparam logic [3:0] PH_ENDPEND  = 4'd7;
  localparam logic [3:0] PH_DONE     = 4'd8;

  localparam logic [0:0] REG_MODE    = 1'd0;
  localparam logic [0:0] REG_CHANNEL = 1'd1;

  localparam logic [31:0] ID_RIFF = 32'h46464952;
  localparam logic [31:0] ID_WAVE = 32'h45564157;
  localparam logic [31:0] ID_FMT  = 32'h20746D66;
  localparam logic [31:0] ID_DATA = 32'h61746164;
  localparam logic [31:0] ID_FORM = 32'h464F524D;
  localparam logic [31:0] ID_8SVX = 32'h38535658;
  localparam logic [31:0] ID_VHDR = 32'h56484452;
  localparam logic [31:0] ID_BODY = 32'h424F4459;

  localparam logic [31:0] FMT_MIN  = 32'd16;
  localparam logic [31:0] VHDR_MIN = 32'd20;

  localparam int OUT_DATA_W = 112;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [5:0]  bits;
    logic [31:0] frames;
    logic [2:0]  err;
  } res_t;

endpackage

// ===== rtl/rid_core.sv =====
// rid_core: byte parser state and per-item conversion logic
// one accepted byte updates the parser state and yields at most one result
// depends on rid_pkg
`timescale 1ns / 1ps

module rid_core import rid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        fire,
  input  logic [7:0]  byte_in,
  input  logic        sof,
  output logic        res_valid,
  output res_t        res
);

  logic        reg_mode_r;
  logic [15:0] reg_chan_r;

  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic [31:0] csize_r, csize_nxt;
  logic [31:0] fsize_r, fsize_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        pad_r, pad_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [2:0]  sbytes_r, sbytes_nxt;
  logic [1:0]  bis_r, bis_nxt;
  logic [15:0] cif_r, cif_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [1:0]  found_r, found_nxt;
  logic        mode_r, mode_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] id_r, id_nxt;

  logic [31:0] pos;
  logic [31:0] off;
  logic [15:0] diff;
  logic [18:0] rest;
  logic [2:0]  bcnt;
  logic [15:0] samp;
  logic [15:0] sel;
  logic        body_end;
  logic        emitted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_mode_r <= 1'b0;
      reg_chan_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    reg_mode_r <= cfg_wdata[0];
        REG_CHANNEL: reg_chan_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = sof ? PH_FILEHDR : phase_r;
    cnt_nxt    = sof ? '0 : cnt_r;
    ws_nxt     = sof ? '0 : ws_r;
    csize_nxt  = sof ? '0 : csize_r;
    fsize_nxt  = sof ? '0 : fsize_r;
    pos        = sof ? '0 : pos_r;
    pad_nxt    = sof ? 1'b0 : pad_r;
    chans_nxt  = sof ? '0 : chans_r;
    sbytes_nxt = sof ? '0 : sbytes_r;
    bis_nxt    = sof ? '0 : bis_r;
    cif_nxt    = sof ? '0 : cif_r;
    frames_nxt = sof ? '0 : frames_r;
    found_nxt  = sof ? '0 : found_r;
    mode_nxt   = sof ? reg_mode_r : mode_r;
    rate_nxt   = sof ? '0 : rate_r;
    id_nxt     = sof ? '0 : id_r;
    pos_nxt    = pos + 32'd1;
    off        = csize_nxt - cnt_nxt;
    diff       = '0;
    rest       = '0;
    bcnt       = '0;
    samp       = '0;
    sel        = '0;
    body_end   = 1'b0;
    emitted    = 1'b0;
    res_valid  = 1'b0;
    res        = '0;

    if (phase_nxt == PH_FILEHDR && pos == 32'd0) mode_nxt = reg_mode_r;

    // shift the byte in for all phases that collect words
    if (phase_nxt == PH_FILEHDR || phase_nxt == PH_CHUNKHDR || phase_nxt == PH_FMT ||
        phase_nxt == PH_VHDR || phase_nxt == PH_DATA) begin
      if (!mode_nxt) ws_nxt = {byte_in, ws_nxt[31:8]};
      else ws_nxt = {ws_nxt[23:0], byte_in};
    end

    unique case (phase_nxt)
      PH_FILEHDR: begin
        if (pos == 32'd3 && ws_nxt != (mode_nxt ? ID_FORM : ID_RIFF)) begin
          phase_nxt = PH_DONE;
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = ERR_MAGIC;
        end else begin
          if (pos == 32'd7) fsize_nxt = ws_nxt;
          if (pos >= 32'd11) begin
            if (ws_nxt != (mode_nxt ? ID_8SVX : ID_WAVE)) begin
              phase_nxt = PH_DONE;
              res_valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.err   = ERR_MAGIC;
            end else begin
              cnt_nxt   = 32'd8;
              phase_nxt = PH_CHUNKHDR;
            end
          end
        end
      end
      PH_CHUNKHDR: begin
        if (cnt_nxt == 32'd8 && {1'b0, pos} >= ({1'b0, fsize_nxt} + 33'd8)) begin
          phase_nxt = PH_DONE;
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = ERR_HEADER;
        end else begin
          cnt_nxt = cnt_nxt - 32'd1;
          if (cnt_nxt == 32'd4) id_nxt = ws_nxt;
          if (cnt_nxt == 32'd0) begin
            csize_nxt = ws_nxt;
            cnt_nxt   = ws_nxt;
            pad_nxt   = ws_nxt[0];
            if (id_nxt == 32'd0) begin
              phase_nxt = PH_DONE;
              res_valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.err   = ERR_HEADER;
            end else if (id_nxt == (mode_nxt ? ID_VHDR : ID_FMT)) begin
              if (ws_nxt < (mode_nxt ? VHDR_MIN : FMT_MIN)) begin
                phase_nxt = PH_DONE;
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
                res.err   = ERR_HEADER;
              end else begin
                phase_nxt = mode_nxt ? PH_VHDR : PH_FMT;
              end
            end else if (id_nxt == (mode_nxt ? ID_BODY : ID_DATA)) begin
              if (!found_nxt[0]) begin
                phase_nxt = PH_DONE;
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
                res.err   = ERR_HEADER;
              end else if (!mode_nxt && reg_chan_r >= chans_nxt) begin
                phase_nxt = PH_DONE;
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
                res.err   = ERR_CHANNEL;
              end else begin
                found_nxt[1] = 1'b1;
                bis_nxt      = '0;
                cif_nxt      = '0;
                frames_nxt   = '0;
                if (ws_nxt == 32'd0) begin
                  phase_nxt = PH_DONE;
                  res_valid = 1'b1;
                  res.kind  = KIND_END;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end else if (ws_nxt == 32'd0) begin
              body_end = 1'b1;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
      end
      PH_FMT: begin
        cnt_nxt = cnt_nxt - 32'd1;
        if (off == 32'd1 && ws_nxt[31:16] != 16'd1) begin
          phase_nxt = PH_DONE;
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = ERR_NOT_PCM;
        end else begin
          if (off == 32'd3) chans_nxt = ws_nxt[31:16];
          if (off == 32'd7) rate_nxt = ws_nxt;
          if (off == 32'd15 && ws_nxt[31:16] != 16'd8 && ws_nxt[31:16] != 16'd16 &&
              ws_nxt[31:16] != 16'd32) begin
            phase_nxt = PH_DONE;
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_DEPTH;
          end else begin
            if (off == 32'd15) begin
              sbytes_nxt   = ws_nxt[21:19];
              found_nxt[0] = 1'b1;
              res_valid    = 1'b1;
              res.kind     = KIND_FORMAT;
              res.rate     = rate_nxt;
              res.chans    = chans_nxt;
              res.bits     = ws_nxt[21:16];
            end
            if (cnt_nxt == 32'd0) body_end = 1'b1;
          end
        end
      end
      PH_VHDR: begin
        cnt_nxt = cnt_nxt - 32'd1;
        if (off == 32'd13) rate_nxt = {16'd0, ws_nxt[15:0]};
        if (off == 32'd15 && byte_in != 8'd0) begin
          phase_nxt = PH_DONE;
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = ERR_NOT_PCM;
        end else begin
          if (off == 32'd19) begin
            chans_nxt    = 16'd1;
            sbytes_nxt   = 3'd1;
            found_nxt[0] = 1'b1;
            res_valid    = 1'b1;
            res.kind     = KIND_FORMAT;
            res.rate     = rate_nxt;
            res.chans    = 16'd1;
            res.bits     = 6'd8;
          end
          if (cnt_nxt == 32'd0) body_end = 1'b1;
        end
      end
      PH_SKIP: begin
        cnt_nxt = cnt_nxt - 32'd1;
        if (cnt_nxt == 32'd0) body_end = 1'b1;
      end
      PH_DATA: begin
        cnt_nxt = cnt_nxt - 32'd1;
        bcnt    = {1'b0, bis_nxt} + 3'd1;
        if (bcnt >= sbytes_nxt) begin
          sel = mode_nxt ? 16'd0 : reg_chan_r;
          if (mode_nxt) samp = {byte_in, 8'd0};
          else if (sbytes_nxt == 3'd1) samp = {byte_in ^ 8'h80, 8'd0};
          else samp = ws_nxt[31:16];
          diff = chans_nxt - 16'd1 - cif_nxt;
          rest = 19'(diff) * 19'(sbytes_nxt);
          if (cif_nxt == sel && cnt_nxt >= {13'd0, rest}) begin
            emitted    = 1'b1;
            res_valid  = 1'b1;
            res.kind   = KIND_SAMPLE;
            res.sample = samp;
          end
          bis_nxt = '0;
          if (cif_nxt + 16'd1 >= chans_nxt) begin
            cif_nxt    = '0;
            frames_nxt = frames_nxt + 32'd1;
          end else begin
            cif_nxt = cif_nxt + 16'd1;
          end
        end else begin
          bis_nxt = bcnt[1:0];
        end
        if (cnt_nxt == 32'd0) begin
          if (emitted) begin
            phase_nxt = PH_ENDPEND;
          end else begin
            phase_nxt  = PH_DONE;
            res_valid  = 1'b1;
            res.kind   = KIND_END;
            res.frames = frames_nxt;
          end
        end
      end
      PH_PAD: begin
        cnt_nxt   = 32'd8;
        phase_nxt = PH_CHUNKHDR;
      end
      PH_ENDPEND: begin
        phase_nxt  = PH_DONE;
        res_valid  = 1'b1;
        res.kind   = KIND_END;
        res.frames = frames_nxt;
      end
      default: ;
    endcase

    if (body_end) begin
      if (pad_nxt) begin
        phase_nxt = PH_PAD;
      end else begin
        cnt_nxt   = 32'd8;
        phase_nxt = PH_CHUNKHDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FILEHDR;
      cnt_r    <= '0;
      ws_r     <= '0;
      csize_r  <= '0;
      fsize_r  <= '0;
      pos_r    <= '0;
      pad_r    <= 1'b0;
      chans_r  <= '0;
      sbytes_r <= '0;
      bis_r    <= '0;
      cif_r    <= '0;
      frames_r <= '0;
      found_r  <= '0;
      mode_r   <= 1'b0;
      rate_r   <= '0;
      id_r     <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      ws_r     <= ws_nxt;
      csize_r  <= csize_nxt;
      fsize_r  <= fsize_nxt;
      pos_r    <= pos_nxt;
      pad_r    <= pad_nxt;
      chans_r  <= chans_nxt;
      sbytes_r <= sbytes_nxt;
      bis_r    <= bis_nxt;
      cif_r    <= cif_nxt;
      frames_r <= frames_nxt;
      found_r  <= found_nxt;
      mode_r   <= mode_nxt;
      rate_r   <= rate_nxt;
      id_r     <= id_nxt;
    end
  end

endmodule

// ===== rtl/riff_iff_audio_deframer.sv =====
// Streaming RIFF/WAVE and IFF/8SVX audio deframer. Takes one file byte per item and
// returns format info, converted 16-bit samples of one channel, an end-of-data frame
// count or an error code. One byte is accepted every cycle unless output stalls;
// a result passes from the input register through the parser step into the result
// register; it frees in the same cycle it is taken. Configuration (mode, channel)
// is to be written by the user between files, which the block does not enforce;
// the mode is latched on the first byte. Depends on rid_pkg and rid_core.
`timescale 1ns / 1ps

module riff_iff_audio_deframer import rid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // in_byte
  input  logic [0:0]            in_tuser,   // start_of_file
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // sample_value, rate_hz, channel_count, sample_bits, frames_seen, error_code
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser   // result_kind
);

  logic       iv_r;
  logic [7:0] ib_r;
  logic       is_r;
  logic       ov_r;
  res_t       ores_r;
  logic       adv;
  logic       res_valid;
  res_t       res;

  assign adv       = iv_r && (!ov_r || out_tready);
  assign in_tready = !iv_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_tready) begin
      iv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ib_r <= in_tdata;
      is_r <= in_tuser[0];
    end
  end

  rid_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (adv),
    .byte_in   (ib_r),
    .sof       (is_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= res_valid;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) ores_r <= res;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ores_r.kind;
  assign out_tdata  = {7'd0, ores_r.err, ores_r.frames, ores_r.bits, ores_r.chans,
                       ores_r.rate, ores_r.sample};

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!iv_r |-> in_tready)) else $error("input stalled with empty input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)))
    else $error("pending result lost");

  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_SAMPLE |-> out_tdata[OUT_DATA_W-1:16] == '0))
    else $error("sample result carries other fields");
`endif

endmodule
